// ===== src/assert_macros.svh =====
// Concurrent assertion helpers for the overdrive pipeline.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define SCOM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge out of reset.
`define SCOM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/scom_pkg.sv =====
`default_nettype none

package scom_pkg;

  localparam int unsigned SampleBits = 24;
  localparam int unsigned FracBits   = SampleBits - 1;

  localparam int unsigned DepthBits   = 7;
  localparam int unsigned GainBits    = 8;
  localparam int unsigned CfgDataBits = 8;

  localparam logic [DepthBits-1:0] DepthReset = 7'd50;
  localparam logic [GainBits-1:0]  GainReset  = 8'd100;

  typedef enum logic {
    CfgDepth = 1'b0,
    CfgGain  = 1'b1
  } cfg_reg_e;

  // Pipeline depth: shaper stages, then mix/gain/round stages
  localparam int unsigned ShapeStages = 4;
  localparam int unsigned MixStages   = 6;
  localparam int unsigned Stages      = ShapeStages + MixStages;

  // Shaped value d spans [-2^F, 2^F]
  localparam int unsigned ShapeBits = SampleBits + 1;
  // 100*x + d*depth, |t| <= 227 * 2^F
  localparam int unsigned TermBits  = SampleBits + 9;
  // t * gain
  localparam int unsigned ProdBits  = SampleBits + 17;
  // (|prod| + 5000) / 16 when not saturated, < 625 * 2^F
  localparam int unsigned NumBits   = SampleBits + 9;
  localparam int unsigned NumLoBits = NumBits / 2;
  localparam int unsigned NumHiBits = NumBits - NumLoBits;

  // floor(2^(SampleBits+1) / 3): quotient off by at most one for the shaper numerator
  localparam logic [SampleBits-1:0] Recip3 =
    SampleBits'((64'd1 << (SampleBits + 1)) / 64'd3);
  // floor(2^NumBits / 625): quotient off by at most one for the rounded output
  localparam logic [SampleBits-1:0] Recip625 =
    SampleBits'((64'd1 << NumBits) / 64'd625);

  localparam logic [ProdBits-1:0] RoundHalf = ProdBits'(5000);
  localparam logic [ProdBits-1:0] SatLimit  = ProdBits'(64'd10000 << FracBits);
  localparam logic [NumBits-1:0]  Div625    = NumBits'(625);

  localparam logic signed [SampleBits-1:0] SampMax = {1'b0, {FracBits{1'b1}}};
  localparam logic signed [SampleBits-1:0] SampMin = {1'b1, {FracBits{1'b0}}};

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_in;
    logic                         silent;
    logic                         block_end;
  } scom_in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_out;
    logic                         block_end_out;
  } scom_out_t;

endpackage

`default_nettype wire

// ===== src/scom_shaper.sv =====
`default_nettype none

module scom_shaper (
  input  logic                                  clk_i,
  input  logic [scom_pkg::ShapeStages-1:0]      en_i,
  input  logic signed [scom_pkg::SampleBits-1:0] sample_i,
  input  logic                                  blk_i,
  output logic signed [scom_pkg::SampleBits-1:0] x_o,
  output logic signed [scom_pkg::ShapeBits-1:0]  d_o,
  output logic                                  blk_o
);
  import scom_pkg::*;

  localparam int unsigned SB = SampleBits;

  localparam logic [SB+1:0] OneU = {3'b001, {FracBits{1'b0}}};
  localparam logic [SB+1:0] TwoU = {3'b010, {FracBits{1'b0}}};
  localparam logic [2*SB-1:0] Three2F = {2'b11, {(2*FracBits){1'b0}}};
  localparam logic signed [ShapeBits-1:0] OneS = {2'b01, {FracBits{1'b0}}};

  // stage 1: magnitude, 3|x|, region, distance from 2/3
  logic [SB-1:0]   abs1;
  logic [SB+1:0]   u1, v1_full;
  logic            lin1_d, sat1_d;
  logic signed [SB-1:0] x1_q;
  logic            blk1_q, lin1_q, sat1_q;
  logic [SB-1:0]   v1_q;

  always_comb begin
    abs1    = sample_i[SB-1] ? (~sample_i + 1'b1) : sample_i;
    u1      = {2'b00, abs1} + {1'b0, abs1, 1'b0};
    lin1_d  = u1 < OneU;
    sat1_d  = u1 > TwoU;
    v1_full = TwoU - u1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x1_q   <= sample_i;
      blk1_q <= blk_i;
      lin1_q <= lin1_d;
      sat1_q <= sat1_d;
      v1_q   <= v1_full[SB-1:0];
    end
  end

  // stage 2: square of the distance
  logic [2*SB-1:0] vsq2_d, vsq2_q;
  logic signed [SB-1:0] x2_q;
  logic            blk2_q, lin2_q, sat2_q;

  assign vsq2_d = v1_q * v1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      vsq2_q <= vsq2_d;
      x2_q   <= x1_q;
      blk2_q <= blk1_q;
      lin2_q <= lin1_q;
      sat2_q <= sat1_q;
    end
  end

  // stage 3: numerator over 2^F, estimate quotient by 3
  logic [2*SB-1:0] num3;
  logic [SB:0]     n3_d, n3_q;
  logic [2*SB:0]   p3;
  logic [SB-1:0]   q3_q;
  logic signed [SB-1:0] x3_q;
  logic            blk3_q, lin3_q, sat3_q;

  always_comb begin
    num3 = Three2F - vsq2_q;
    n3_d = num3[2*SB-1:FracBits];
    p3   = n3_d * Recip3;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      n3_q   <= n3_d;
      q3_q   <= p3[2*SB:SB+1];
      x3_q   <= x2_q;
      blk3_q <= blk2_q;
      lin3_q <= lin2_q;
      sat3_q <= sat2_q;
    end
  end

  // stage 4: correct quotient, select region and sign
  logic [SB+1:0]   r4;
  logic [SB-1:0]   mag4;
  logic signed [ShapeBits-1:0] magS4, d4;
  logic            neg4;
  logic signed [SB-1:0] x4_q;
  logic signed [ShapeBits-1:0] d4_q;
  logic            blk4_q;

  always_comb begin
    r4    = {1'b0, n3_q} - ({2'b00, q3_q} + {1'b0, q3_q, 1'b0});
    mag4  = (r4 >= (SB + 2)'(3)) ? (q3_q + 1'b1) : q3_q;
    magS4 = signed'({1'b0, mag4});
    neg4  = x3_q[SB-1];
    if (lin3_q) begin
      d4 = signed'({x3_q, 1'b0});
    end else if (sat3_q) begin
      d4 = neg4 ? -OneS : OneS;
    end else begin
      d4 = neg4 ? -magS4 : magS4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      x4_q   <= x3_q;
      d4_q   <= d4;
      blk4_q <= blk3_q;
    end
  end

  assign x_o   = x4_q;
  assign d_o   = d4_q;
  assign blk_o = blk4_q;

endmodule

`default_nettype wire

// ===== src/soft_clip_overdrive_mix_top.sv =====
// Overdrive waveshaper with dry/wet mix and output gain, one Q1.23 sample per transaction.
// Input channel: in_valid_i/in_ready_o with in_data_i (sample, silent flag, block end).
// Output channel: out_valid_o/out_ready_i with out_data_o (saturated sample, block end).
// A transaction marked silent is taken and dropped; it yields no output transaction.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (depth percent, gain percent). Write only while the pipeline is empty.
// Pipeline: ten stages (shaper square and divide-by-3, mix multiply, gain multiply,
// rounding divide-by-10000 in split partial products).
// Throughput: one transaction per cycle, sustained while out_ready_i stays high.
// Every stage carries its own valid bit; a stage advances when it is empty or the
// stage after it advances, so a stalled receiver fills bubbles first and input
// ready drops only when all ten stages hold data. Nothing is lost or repeated.
// Reset: all stages empty, depth percent 50, gain percent 100.
`default_nettype none
`include "assert_macros.svh"

module soft_clip_overdrive_mix_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  scom_pkg::scom_in_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output scom_pkg::scom_out_t                out_data_o,
  input  logic                               cfg_we_i,
  input  scom_pkg::cfg_reg_e                 cfg_idx_i,
  input  logic [scom_pkg::CfgDataBits-1:0]   cfg_data_i
);
  import scom_pkg::*;

  localparam int unsigned SB = SampleBits;
  localparam int unsigned Last = Stages - 1;

  // configuration registers
  logic [DepthBits-1:0] depth_q;
  logic [GainBits-1:0]  gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DepthReset;
      gain_q  <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDepth: depth_q <= cfg_data_i[DepthBits-1:0];
        CfgGain:  gain_q  <= cfg_data_i[GainBits-1:0];
      endcase
    end
  end

  // pipeline control: advance a stage when empty or when the next one advances
  logic [Stages-1:0] vld_q, adv;

  always_comb begin
    adv[Last] = !vld_q[Last] || out_ready_i;
    for (int i = Last - 1; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i && !in_data_i.silent;
      end
      for (int i = 1; i < Stages; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // stages 1 to 4: shaping curve
  logic signed [SB-1:0]        sh_x;
  logic signed [ShapeBits-1:0] sh_d;
  logic                        sh_blk;

  scom_shaper u_shaper (
    .clk_i    (clk_i),
    .en_i     (adv[ShapeStages-1:0]),
    .sample_i (in_data_i.sample_in),
    .blk_i    (in_data_i.block_end),
    .x_o      (sh_x),
    .d_o      (sh_d),
    .blk_o    (sh_blk)
  );

  // stage 5: dry * 100 + shaped * depth
  localparam logic signed [TermBits-1:0] Hundred = TermBits'(100);
  logic signed [TermBits-1:0] xw5, dw5, depw5, t5_d, t5_q;
  logic                       blk5_q;

  always_comb begin
    xw5   = TermBits'(sh_x);
    dw5   = TermBits'(sh_d);
    depw5 = signed'(TermBits'(depth_q));
    t5_d  = xw5 * Hundred + dw5 * depw5;
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      t5_q   <= t5_d;
      blk5_q <= sh_blk;
    end
  end

  // stage 6: apply gain
  logic signed [ProdBits-1:0] p6_d, p6_q;
  logic                       blk6_q;

  assign p6_d = ProdBits'(t5_q) * signed'(ProdBits'(gain_q));

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      p6_q   <= p6_d;
      blk6_q <= blk5_q;
    end
  end

  // stage 7: magnitude plus half divisor, saturation test, drop the factor 16
  logic                 neg7;
  logic [ProdBits-1:0]  mag7, n7;
  logic [NumBits-1:0]   n7_q;
  logic                 sat7_q, neg7_q, blk7_q;

  always_comb begin
    neg7 = p6_q[ProdBits-1];
    mag7 = neg7 ? (~p6_q + 1'b1) : p6_q;
    n7   = mag7 + RoundHalf;
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      n7_q   <= n7[NumBits+3:4];
      sat7_q <= n7 >= SatLimit;
      neg7_q <= neg7;
      blk7_q <= blk6_q;
    end
  end

  // stage 8: partial products of the reciprocal multiply
  logic [NumLoBits+SB-1:0] plo8_q;
  logic [NumHiBits+SB-1:0] phi8_q;
  logic [NumBits-1:0]      n8_q;
  logic                    sat8_q, neg8_q, blk8_q;

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      plo8_q <= n7_q[NumLoBits-1:0] * Recip625;
      phi8_q <= n7_q[NumBits-1:NumLoBits] * Recip625;
      n8_q   <= n7_q;
      sat8_q <= sat7_q;
      neg8_q <= neg7_q;
      blk8_q <= blk7_q;
    end
  end

  // stage 9: combine partial products into the quotient estimate
  logic [NumBits+SB-1:0] sum9;
  logic [SB-1:0]         q9_q;
  logic [NumBits-1:0]    n9_q;
  logic                  sat9_q, neg9_q, blk9_q;

  assign sum9 = {phi8_q, {NumLoBits{1'b0}}} + (NumBits + SB)'(plo8_q);

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      q9_q   <= sum9[NumBits+SB-1:NumBits];
      n9_q   <= n8_q;
      sat9_q <= sat8_q;
      neg9_q <= neg8_q;
      blk9_q <= blk8_q;
    end
  end

  // stage 10: correct quotient, restore sign, clamp to the rails
  logic [NumBits-1:0]   qx10, r10;
  logic [SB-1:0]        q10;
  logic signed [SB-1:0] y10;
  scom_out_t            out_q;

  always_comb begin
    qx10 = NumBits'(q9_q);
    r10  = n9_q - qx10 * Div625;
    q10  = (r10 >= Div625) ? (q9_q + 1'b1) : q9_q;
    if (sat9_q) begin
      y10 = neg9_q ? SampMin : SampMax;
    end else begin
      y10 = neg9_q ? signed'(~q10 + 1'b1) : signed'(q10);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      out_q.sample_out    <= y10;
      out_q.block_end_out <= blk9_q;
    end
  end

  assign out_valid_o = vld_q[Last];
  assign out_data_o  = out_q;

  `SCOM_ASSERT(silent_dropped_a, in_valid_i && in_ready_o && in_data_i.silent |=> !vld_q[0], "silent transaction entered the pipeline")
  `SCOM_NEVER(blocked_with_bubble_a, !in_ready_o && !(&vld_q), "input stalled while a stage is empty")
  `SCOM_ASSERT(sat_hits_rail_a, vld_q[8] && adv[9] && sat9_q |=> out_data_o.sample_out == SampMax || out_data_o.sample_out == SampMin, "saturated result not at a rail")

endmodule

`default_nettype wire

// ===== tb/scom_checker.sv =====
`default_nettype none

module scom_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  scom_pkg::scom_in_t               in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  scom_pkg::scom_out_t              out_data_i,
  input  logic                             cfg_we_i,
  input  scom_pkg::cfg_reg_e               cfg_idx_i,
  input  logic [scom_pkg::CfgDataBits-1:0] cfg_data_i,
  output int                               mismatches_o,
  output int                               pending_o,
  output int                               results_o
);
  import scom_pkg::*;

  logic [DepthBits-1:0] depth_pct = DepthReset;
  logic [GainBits-1:0]  gain_pct  = GainReset;
  scom_out_t            expected_q[$];

  // Shape the sample on the soft-clip curve, mix with the dry sample, apply gain,
  // round half away from zero, and saturate.
  function automatic scom_out_t overdrive_sample(scom_in_t smp, logic [DepthBits-1:0] depth,
                                                 logic [GainBits-1:0] gain);
    longint    one;
    longint    x;
    longint    a;
    longint    u;
    longint    v;
    longint    mag;
    longint    d;
    longint    t;
    longint    prod;
    longint    pmag;
    longint    q;
    longint    y;
    scom_out_t res;
    one = longint'(1) << FracBits;
    x   = longint'($signed(smp.sample_in));
    a   = (x < 0) ? -x : x;
    u   = 3 * a;
    if (u < one) begin
      d = 2 * x;
    end else begin
      if (u > 2 * one) begin
        mag = one;
      end else begin
        v   = 2 * one - u;
        mag = (3 * one * one - v * v) / (3 * one);
      end
      d = (x < 0) ? -mag : mag;
    end
    t    = 100 * x + d * longint'(depth);
    prod = t * longint'(gain);
    pmag = (prod < 0) ? -prod : prod;
    q    = (pmag + 5000) / 10000;
    y    = (prod < 0) ? -q : q;
    if (y > one - 1) y = one - 1;
    if (y < -one) y = -one;
    res.sample_out    = y[SampleBits-1:0];
    res.block_end_out = smp.block_end;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scom_out_t want;
    if (!rst_ni) begin
      depth_pct = DepthReset;
      gain_pct  = GainReset;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: unexpected output sample=%0d block_end=%0b", $realtime,
                     out_data_i.sample_out, out_data_i.block_end_out);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.sample_out !== want.sample_out ||
              out_data_i.block_end_out !== want.block_end_out) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: mismatch sample exp=%0d got=%0d block_end exp=%0b got=%0b",
                       $realtime, want.sample_out, out_data_i.sample_out,
                       want.block_end_out, out_data_i.block_end_out);
          end
        end
      end
      // silent transactions are swallowed by the block
      if (in_valid_i && in_ready_i && !in_data_i.silent)
        expected_q.push_back(overdrive_sample(in_data_i, depth_pct, gain_pct));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDepth: depth_pct = cfg_data_i[DepthBits-1:0];
          CfgGain:  gain_pct  = cfg_data_i[GainBits-1:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  import scom_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 60;
  localparam int Third      = (1 << FracBits) / 3;
  localparam int TwoThird   = (2 << FracBits) / 3;
  localparam int NumPhases  = 8;
  localparam int PhaseItems = 130;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid;
  logic                   in_ready;
  scom_in_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  scom_out_t              out_data;
  logic                   cfg_we;
  cfg_reg_e               cfg_idx;
  logic [CfgDataBits-1:0] cfg_data;

  int mismatches;
  int pending;
  int results;

  int cycle_cnt = 0;
  int n_sent    = 0;
  int n_silent  = 0;
  int src_rate  = 0;
  int sink_rate = 0;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  soft_clip_overdrive_mix_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  scom_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .results_o   (results)
  );

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: random backpressure bursts, plus one long hold on request.
  initial begin
    bit held;
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        held = 1'b1;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < sink_rate) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Hold valid until the transaction goes through; drop it only for an idle burst.
  task automatic offer(input logic signed [SampleBits-1:0] smp, input logic silent,
                       input logic blk_end);
    scom_in_t it;
    it.sample_in = smp;
    it.silent    = silent;
    it.block_end = blk_end;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    n_sent++;
    if (silent) n_silent++;
    if (!calm && $urandom_range(0, 99) < src_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Let the pipe settle before writing the mix registers.
  task automatic set_mix(input logic [CfgDataBits-1:0] depth, input logic [CfgDataBits-1:0] gain);
    drain_results();
    repeat (14) @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgDepth;
    cfg_data <= depth;
    @(negedge clk_i);
    cfg_idx  <= CfgGain;
    cfg_data <= gain;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic signed [SampleBits-1:0] pick_sample();
    logic signed [SampleBits-1:0] s;
    case ($urandom_range(0, 7))
      3:       s = SampleBits'(Third + int'($urandom_range(0, 8)) - 4);
      4:       s = SampleBits'(TwoThird + int'($urandom_range(0, 8)) - 4);
      5:       s = SampleBits'($urandom_range(0, 2000));
      6: begin
        case ($urandom_range(0, 3))
          0:       s = SampMax;
          1:       s = SampMin;
          2:       s = '0;
          default: s = '1;
        endcase
      end
      7:       s = SampleBits'($urandom_range(0, (1 << FracBits) - 1));
      default: s = SampleBits'($urandom);
    endcase
    if (($urandom_range(0, 1) == 1) && s != SampMin && s != SampMax) s = -s;
    return s;
  endfunction

  initial begin
    int                     blk_len;
    int                     pos;
    int                     n;
    logic [CfgDataBits-1:0] dw;
    logic [CfgDataBits-1:0] gw;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CfgDepth;
    cfg_data <= '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: region boundaries of the curve, extremes, silent and block end.
    src_rate  = 20;
    sink_rate = 20;
    offer('0, 1'b0, 1'b0);
    offer(SampleBits'(1), 1'b0, 1'b0);
    offer('1, 1'b0, 1'b0);
    offer(SampMax, 1'b0, 1'b0);
    offer(SampMin, 1'b0, 1'b0);
    offer(SampleBits'(Third), 1'b0, 1'b0);
    offer(SampleBits'(Third + 1), 1'b0, 1'b0);
    offer(SampleBits'(-Third), 1'b0, 1'b0);
    offer(SampleBits'(-Third - 1), 1'b0, 1'b0);
    offer(SampleBits'(TwoThird), 1'b0, 1'b0);
    offer(SampleBits'(TwoThird + 1), 1'b0, 1'b0);
    offer(SampleBits'(-TwoThird), 1'b0, 1'b0);
    offer(SampleBits'(-TwoThird - 1), 1'b0, 1'b0);
    offer(SampleBits'(4000000), 1'b0, 1'b0);
    offer(SampleBits'(-4000000), 1'b0, 1'b1);
    offer(SampMax, 1'b1, 1'b1);
    offer('0, 1'b1, 1'b0);
    offer(SampMin, 1'b0, 1'b1);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin dw = 8'd0;   gw = 8'd0;   src_rate = 25; sink_rate = 25; end
        1: begin dw = 8'd100; gw = 8'd200; src_rate = 0;  sink_rate = 10; end
        2: begin dw = 8'd127; gw = 8'd255; src_rate = 0;  sink_rate = 0;  end
        // depth register keeps seven bits only
        3: begin dw = 8'hE4;  gw = 8'd1;   src_rate = 30; sink_rate = 30; end
        4: begin dw = 8'd0;   gw = 8'd200; src_rate = 15; sink_rate = 40; end
        5: begin dw = 8'd100; gw = 8'd0;   src_rate = 40; sink_rate = 15; end
        6: begin
          dw = CfgDataBits'($urandom_range(0, 100));
          gw = CfgDataBits'($urandom_range(0, 200));
          src_rate = 20;
          sink_rate = 20;
        end
        default: begin dw = 8'd50; gw = 8'd100; calm = 1'b1; end
      endcase
      set_mix(dw, gw);
      if (ph == 1) hold_req = 1'b1;
      n = 0;
      while (n < PhaseItems) begin
        blk_len = $urandom_range(1, 16);
        for (pos = 0; pos < blk_len && n < PhaseItems; pos++) begin
          offer(pick_sample(), $urandom_range(0, 7) == 0, pos == blk_len - 1);
          n++;
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d samples (%0d silent) over %0d mix/gain settings, %0d results checked",
             n_sent, n_silent, NumPhases + 1, results);
    $display("Covered curve region edges, full scale, out-of-range registers and stalls");
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/scom_pkg.sv
src/scom_shaper.sv
src/soft_clip_overdrive_mix_top.sv
tb/scom_checker.sv
tb/tb.sv
